>>> hw/rtl/tmen_pkg.sv
// Shared types and codes for the ticket mutual exclusion node.
// Item structs, message and input kind codes, controller/datapath links.
// No dependencies.
package tmen_pkg;

	// input item kinds
	localparam logic [1:0] KIND_LOCAL_REQ = 2'd0;
	localparam logic [1:0] KIND_PEER_REQ  = 2'd1;
	localparam logic [1:0] KIND_PEER_REP  = 2'd2;
	localparam logic [1:0] KIND_RELEASE   = 2'd3;

	// outgoing message kinds
	localparam logic [1:0] MSG_REQUEST = 2'd0;
	localparam logic [1:0] MSG_REPLY   = 2'd1;
	localparam logic [1:0] MSG_GRANT   = 2'd2;

	localparam int ID_W   = 3;
	localparam int TKT_W  = 16;

	typedef struct packed {
		logic [1:0]       kind;
		logic [ID_W-1:0]  peer_id;
		logic [TKT_W-1:0] peer_ticket;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       message_kind;
		logic [ID_W-1:0]  dest_id;
		logic [TKT_W-1:0] ticket_out;
		logic             last;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;   // capture the accepted item
		logic exec;   // apply the item to the node state
		logic step;   // advance the fan-out scan position
		logic pick;   // emit the message at the scan position
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic single;      // item yields one message right away
		logic fan;         // item starts a fan-out scan
		logic hit;         // scan position has a message to send
		logic pend_empty;  // nothing left to send
	} status_t;

endpackage

>>> hw/rtl/tmen_ctrl.sv
// Controller state machine of the ticket mutual exclusion node.
// Sequences accept, evaluation, fan-out scan and result handoff.
// Depends on tmen_pkg.
module tmen_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	output logic             result_valid,
	input  logic             result_ready,
	input  tmen_pkg::status_t status,
	output tmen_pkg::cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EVAL = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_SEND = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (status.single) state_d = ST_SEND;
				else if (status.fan) state_d = ST_SCAN;
				else state_d = ST_IDLE;
			end
			ST_SCAN: begin
				if (status.pend_empty) state_d = ST_IDLE;
				else if (status.hit) state_d = ST_SEND;
			end
			ST_SEND: begin
				if (result_ready) state_d = status.pend_empty ? ST_IDLE : ST_SCAN;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = (state_q == ST_SEND);

	always_comb begin
		cmd      = '0;
		cmd.load = (state_q == ST_IDLE) && item_valid;
		cmd.exec = (state_q == ST_EVAL);
		cmd.step = (state_q == ST_SCAN) && !status.pend_empty;
		cmd.pick = (state_q == ST_SCAN) && !status.pend_empty && status.hit;
	end

endmodule

>>> hw/rtl/tmen_datapath.sv
// Datapath of the ticket mutual exclusion node: node state, tickets,
// deferred flags, fan-out mask and scan counter, result register.
// Depends on tmen_pkg.
module tmen_datapath #(
	parameter int NODE_COUNT  = 5,
	parameter int TICKET_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tmen_pkg::in_item_t             item,
	input  logic                           cfg_valid,
	input  logic [tmen_pkg::ID_W-1:0]      cfg_data,
	input  tmen_pkg::cmd_t                 cmd,
	output tmen_pkg::status_t              status,
	output tmen_pkg::out_item_t            result
);

	localparam int IDX_W = $clog2(NODE_COUNT);
	localparam int RW    = $clog2(NODE_COUNT);
	localparam logic [RW-1:0] REPLY_ALL = RW'(NODE_COUNT - 1);
	localparam logic [TICKET_BITS-1:0] TMAX = {TICKET_BITS{1'b1}};

	tmen_pkg::in_item_t          item_q;
	tmen_pkg::out_item_t         out_q;
	logic [tmen_pkg::ID_W-1:0]   own_id_q;
	logic [TICKET_BITS-1:0]      highest_q;
	logic [TICKET_BITS-1:0]      own_ticket_q;
	logic                        wanting_q;
	logic [RW-1:0]               replies_q;
	logic [NODE_COUNT-1:0]       deferred_q;
	logic [NODE_COUNT-1:0]       pending_q;
	logic [1:0]                  fan_kind_q;
	logic [IDX_W-1:0]            cnt_q;

	logic [TICKET_BITS+15:0]     pt_ext, own_ext;
	logic [TICKET_BITS-1:0]      pt;
	logic [tmen_pkg::ID_W-1:0]   pid;
	logic                        own_ok, peer_ok, answer_now;
	logic                        req_go, preq_go, rep_go, rel_go, grant_now;
	logic [NODE_COUNT-1:0]       req_mask, peer_hot, cnt_hot;
	logic [IDX_W+2:0]            dest_ext;
	tmen_pkg::out_item_t         single_msg, scan_msg;

	assign pid     = item_q.peer_id;
	assign pt_ext  = (TICKET_BITS+16)'(item_q.peer_ticket);
	assign pt      = pt_ext[TICKET_BITS-1:0];
	assign own_ext = (TICKET_BITS+16)'(own_ticket_q);

	assign own_ok  = (own_id_q != '0) && (32'(own_id_q) <= NODE_COUNT);
	assign peer_ok = (pid != '0) && (32'(pid) <= NODE_COUNT) && (pid != own_id_q);

	// peer is answered at once unless we want the section and hold priority
	assign answer_now = !wanting_q || (own_ticket_q > pt) ||
		((own_ticket_q == pt) && (own_id_q > pid));

	assign req_go    = (item_q.kind == tmen_pkg::KIND_LOCAL_REQ) && !wanting_q && own_ok;
	assign preq_go   = (item_q.kind == tmen_pkg::KIND_PEER_REQ) && peer_ok;
	assign rep_go    = (item_q.kind == tmen_pkg::KIND_PEER_REP) && wanting_q && peer_ok &&
		(replies_q < REPLY_ALL);
	assign rel_go    = (item_q.kind == tmen_pkg::KIND_RELEASE) && wanting_q &&
		(replies_q == REPLY_ALL);
	assign grant_now = (RW'(replies_q + 1'b1) == REPLY_ALL);

	always_comb begin
		for (int i = 0; i < NODE_COUNT; i++) begin
			req_mask[i] = (32'(own_id_q) != 32'(i + 1));
			peer_hot[i] = (32'(pid) == 32'(i + 1));
		end
	end

	assign cnt_hot  = {{(NODE_COUNT-1){1'b0}}, 1'b1} << cnt_q;
	assign dest_ext = (IDX_W+3)'(cnt_q) + 1'b1;

	always_comb begin
		single_msg = '0;
		single_msg.last = 1'b1;
		if (preq_go) begin
			single_msg.message_kind = tmen_pkg::MSG_REPLY;
			single_msg.dest_id      = pid;
		end else begin
			single_msg.message_kind = tmen_pkg::MSG_GRANT;
		end
	end

	always_comb begin
		scan_msg              = '0;
		scan_msg.message_kind = fan_kind_q;
		scan_msg.dest_id      = dest_ext[2:0];
		if (fan_kind_q == tmen_pkg::MSG_REQUEST) scan_msg.ticket_out = own_ext[15:0];
		scan_msg.last         = ((pending_q & ~cnt_hot) == '0);
	end

	always_comb begin
		status            = '0;
		status.single     = (preq_go && answer_now) || (rep_go && grant_now);
		status.fan        = req_go || rel_go;
		status.hit        = pending_q[cnt_q];
		status.pend_empty = (pending_q == '0);
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= item;
		if (cmd.exec && status.single) out_q <= single_msg;
		else if (cmd.pick) out_q <= scan_msg;
		if (cmd.exec && req_go) fan_kind_q <= tmen_pkg::MSG_REQUEST;
		else if (cmd.exec && rel_go) fan_kind_q <= tmen_pkg::MSG_REPLY;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q     <= tmen_pkg::ID_W'(1);
			highest_q    <= '0;
			own_ticket_q <= '0;
			wanting_q    <= 1'b0;
			replies_q    <= '0;
			deferred_q   <= '0;
			pending_q    <= '0;
			cnt_q        <= '0;
		end else begin
			if (cfg_valid) own_id_q <= cfg_data;
			if (cmd.exec) begin
				cnt_q <= '0;
				if (req_go) begin
					wanting_q    <= 1'b1;
					replies_q    <= '0;
					own_ticket_q <= highest_q;
					pending_q    <= req_mask;
					if (highest_q != TMAX) highest_q <= highest_q + 1'b1;
				end
				if (preq_go) begin
					if (pt > highest_q) highest_q <= pt;
					if (!answer_now) deferred_q <= deferred_q | peer_hot;
				end
				if (rep_go) replies_q <= RW'(replies_q + 1'b1);
				if (rel_go) begin
					wanting_q  <= 1'b0;
					replies_q  <= '0;
					pending_q  <= deferred_q;
					deferred_q <= '0;
				end
			end else begin
				// drop the sent position, advance the scan
				if (cmd.pick) pending_q <= pending_q & ~cnt_hot;
				if (cmd.step) cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign result = out_q;

endmodule

>>> hw/rtl/ticket_mutual_exclusion_node_unit.sv
// Top level of the ticket mutual exclusion node.
// Joins the controller and datapath; holds the port-level assertions.
// Depends on tmen_pkg, tmen_ctrl, tmen_datapath.

// One node of ticket-based distributed mutual exclusion. Feed it local
// requests and releases and the requests and replies that arrive from peers;
// it returns the messages to send (requests to every other node, replies) and
// a grant when all NODE_COUNT-1 peers have replied. A local request takes the
// highest ticket seen as its own and bumps that ticket, saturating at the top
// of TICKET_BITS. A peer request is answered at once unless this node wants
// the section and holds the smaller ticket (ties go to the smaller id); then it
// is deferred until release. Each result carries last on the final message
// of its item. The node id register is written through the cfg channel, which
// is always ready; write it only while the node is idle. Items are handled one
// at a time: each item is accepted and then evaluated; an item with a single
// result then shows it on the next cycle; a request or release walks one node
// position per cycle with a single scan counter, pausing at each message until
// the result port takes it. No clearing pass follows reset.
module ticket_mutual_exclusion_node_unit #(
	parameter int NODE_COUNT  = 5,
	parameter int TICKET_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// input items
	input  logic                      item_valid,
	output logic                      item_ready,
	input  tmen_pkg::in_item_t        item,
	// result items
	output logic                      result_valid,
	input  logic                      result_ready,
	output tmen_pkg::out_item_t       result,
	// node id register
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [tmen_pkg::ID_W-1:0] cfg_data
);

	tmen_pkg::cmd_t    cmd;
	tmen_pkg::status_t status;

	// the id register takes a write in any cycle
	assign cfg_ready = 1'b1;

	tmen_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.cmd          (cmd)
	);

	tmen_datapath #(
		.NODE_COUNT  (NODE_COUNT),
		.TICKET_BITS (TICKET_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.result    (result)
	);

`ifndef ASSERT_OFF
	// one item at a time: never take an item while a result is shown
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> !result_valid)
		else $error("item accepted while a result is pending");

	// a grant always closes its item
	a_grant_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.message_kind == tmen_pkg::MSG_GRANT)) |-> result.last)
		else $error("grant without last");

	// a shown result that is taken without last is followed by more work, not idle
	a_more_after: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_ready && !result.last) |=> !item_ready)
		else $error("node went idle before the last result");
`endif

endmodule
